/* src/kfp_pkg.sv */
// Package for the Keccak-f[1600] permutation block.
// Holds lane and state types, counter widths, LFSR constants and rotation offsets.
`default_nettype none

package kfp_pkg;

    localparam int LANES  = 25;
    localparam int LANE_W = 64;
    localparam int CNT_W  = 5;
    localparam int LFSR_W = 8;
    localparam int RC_BITS = 7;

    localparam logic [CNT_W-1:0]  LAST_LANE = CNT_W'(LANES - 1);
    localparam logic [LFSR_W-1:0] LFSR_SEED = 8'h01;
    localparam logic [LFSR_W-1:0] LFSR_POLY = 8'h71;

    typedef logic [LANE_W-1:0]            lane_t;
    typedef logic [LANES-1:0][LANE_W-1:0] state_t;
    typedef logic [LFSR_W-1:0]            lfsr_t;

    // rho rotation amount for lane x+5y
    localparam int RHO_OFS [LANES] = '{
         0,  1, 62, 28, 27,
        36, 44,  6, 55, 20,
         3, 10, 43, 25, 39,
        41, 45, 15, 21,  8,
        18,  2, 61, 56, 14
    };

    function automatic lane_t rotl(input lane_t v, input int n);
        logic [2*LANE_W-1:0] tmp;
        begin
            tmp = {v, v} << n;
            return tmp[2*LANE_W-1:LANE_W];
        end
    endfunction

endpackage

`default_nettype wire

/* src/kfp_lfsr.sv */
// Round-constant generator: seven steps of the degree-8 LFSR per round.
// Depends on kfp_pkg for the LFSR and lane types.
`default_nettype none

module kfp_lfsr (
    input  wire kfp_pkg::lfsr_t lfsr_cur,
    output kfp_pkg::lfsr_t      lfsr_nxt,
    output kfp_pkg::lane_t      round_const
);
    import kfp_pkg::*;

    lfsr_t v;

    always_comb begin
        v           = lfsr_cur;
        round_const = '0;
        for (int j = 0; j < RC_BITS; j++) begin
            round_const[(1 << j) - 1] = v[0];
            if (v[LFSR_W-1]) begin
                v = (v << 1) ^ LFSR_POLY;
            end else begin
                v = v << 1;
            end
        end
        lfsr_nxt = v;
    end

endmodule

`default_nettype wire

/* src/kfp_round.sv */
// One Keccak-f[1600] round: theta, rho with pi, chi and iota.
// Depends on kfp_pkg for state types and rotation offsets.
`default_nettype none

module kfp_round (
    input  wire kfp_pkg::state_t state_in,
    input  wire kfp_pkg::lane_t  round_const,
    output kfp_pkg::state_t      state_out
);
    import kfp_pkg::*;

    lane_t  c [5];
    lane_t  d [5];
    state_t a;
    state_t b;

    always_comb begin
        for (int x = 0; x < 5; x++) begin
            c[x] = state_in[x] ^ state_in[x + 5] ^ state_in[x + 10]
                 ^ state_in[x + 15] ^ state_in[x + 20];
        end
        for (int x = 0; x < 5; x++) begin
            d[x] = c[(x + 4) % 5] ^ rotl(c[(x + 1) % 5], 1);
        end
        for (int i = 0; i < LANES; i++) begin
            a[i] = state_in[i] ^ d[i % 5];
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                b[y + 5 * ((2 * x + 3 * y) % 5)] = rotl(a[x + 5 * y], RHO_OFS[x + 5 * y]);
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                state_out[x + 5 * y] = b[x + 5 * y]
                    ^ (~b[(x + 1) % 5 + 5 * y] & b[(x + 2) % 5 + 5 * y]);
            end
        end
        state_out[0] = state_out[0] ^ round_const;
    end

endmodule

`default_nettype wire

/* src/keccak_f1600_permutation.sv */
// Keccak-f[1600] permutation, lane-serial in and out, one round per cycle.
// Depends on kfp_pkg, kfp_round and kfp_lfsr.
//
// Send the 25 lanes of the state on the s_ stream in index order x+5y; after
// the 25th transaction the block runs ROUNDS rounds, one per clock cycle in a
// single round unit, with round constants from the 8-bit LFSR, then returns
// the 25 permuted lanes in the same order on the m_ stream, with the lane
// index in m_tuser and m_tlast on lane 24. A full permutation has a load
// phase, a round phase and an emit phase that back-pressure on m_tready can
// stall; s_tready is low from the 25th lane until the last result lane is
// taken.
`default_nettype none

module keccak_f1600_permutation #(
    parameter int ROUNDS = 24
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire kfp_pkg::lane_t s_tdata,   // [63:0] lane_in
    output logic                m_tvalid,
    input  wire                 m_tready,
    output kfp_pkg::lane_t      m_tdata,   // [63:0] lane_out
    output logic [4:0]          m_tuser,   // [4:0] lane_number
    output logic                m_tlast
);
    import kfp_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_EMIT
    } fsm_t;

    fsm_t             state_reg;
    logic [CNT_W-1:0] lane_cnt_reg;
    logic [CNT_W-1:0] round_cnt_reg;
    lfsr_t            lfsr_reg;
    state_t           lanes_reg;
    state_t           lanes_next;
    state_t           round_out;
    lfsr_t            lfsr_next;
    lane_t            round_const;

    logic s_fire;
    logic m_fire;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = lanes_reg[0];
    assign m_tuser  = lane_cnt_reg;
    assign m_tlast  = (state_reg == ST_EMIT) && (lane_cnt_reg == LAST_LANE);

    kfp_lfsr u_lfsr (
        .lfsr_cur    (lfsr_reg),
        .lfsr_nxt    (lfsr_next),
        .round_const (round_const)
    );

    kfp_round u_round (
        .state_in    (lanes_reg),
        .round_const (round_const),
        .state_out   (round_out)
    );

    // shift in at lane 24, shift out from lane 0
    always_comb begin
        lanes_next = lanes_reg;
        if (s_fire) begin
            lanes_next = {s_tdata, lanes_reg[LANES-1:1]};
        end else if (state_reg == ST_ROUND) begin
            lanes_next = round_out;
        end else if (m_fire) begin
            lanes_next = {lanes_reg[0], lanes_reg[LANES-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            lane_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            lfsr_reg      <= LFSR_SEED;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (lane_cnt_reg == LAST_LANE) begin
                            lane_cnt_reg  <= '0;
                            round_cnt_reg <= '0;
                            lfsr_reg      <= LFSR_SEED;
                            state_reg     <= ST_ROUND;
                        end else begin
                            lane_cnt_reg <= lane_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_ROUND: begin
                    lfsr_reg <= lfsr_next;
                    if (round_cnt_reg == CNT_W'(ROUNDS - 1)) begin
                        round_cnt_reg <= '0;
                        state_reg     <= ST_EMIT;
                    end else begin
                        round_cnt_reg <= round_cnt_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (m_fire) begin
                        if (lane_cnt_reg == LAST_LANE) begin
                            lane_cnt_reg <= '0;
                            state_reg    <= ST_LOAD;
                        end else begin
                            lane_cnt_reg <= lane_cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* test/keccak_f1600_permutation_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for keccak_f1600_permutation: streams 25-lane states in, checks
// every permuted lane, index and last flag against a behavioral Keccak-f[1600] model.
// Depends on kfp_pkg and the block's RTL.
module keccak_f1600_permutation_tb;
    import kfp_pkg::*;

    localparam int NUM_ROUNDS   = 24;
    localparam int RANDOM_SETS  = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        lane_t      lane;
        logic [4:0] number;
        logic       is_last;
    } out_lane_t;

    typedef enum int {FILL_RANDOM, FILL_SINGLE_BIT, FILL_SOLID, FILL_SPARSE} fill_style_t;
    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_mode_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    lane_t      s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    lane_t      m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    out_lane_t lanes_due[$];
    state_t    loaded_state;
    int        loaded_count = 0;
    int        error_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    bit        hold_out_req = 1'b0;
    bit        hold_out_done = 1'b0;

    lane_t directed_lanes [LANES] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
        64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
        64'hFEDC_BA98_7654_3210, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
        64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0F0F_0F0F_0F0F_0F0F,
        64'hF0F0_F0F0_F0F0_F0F0, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000,
        64'hDEAD_BEEF_CAFE_F00D, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h3333_CCCC_3333_CCCC, 64'h0000_0000_0000_0006, 64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF
    };

    keccak_f1600_permutation #(
        .ROUNDS(NUM_ROUNDS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    function automatic lane_t rot_left(input lane_t v, input int n);
        if (n == 0)
            return v;
        return (v << n) | (v >> (LANE_W - n));
    endfunction

    function automatic state_t keccak_permute(input state_t a);
        lane_t col [5];
        lane_t row [5];
        lane_t d;
        lane_t cur;
        lane_t nxt;
        lfsr_t rc_lfsr;
        logic  rc_bit;
        int    rnd, x, y, t, ny, j;
        rc_lfsr = LFSR_SEED;
        for (rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
            for (x = 0; x < 5; x++)
                col[x] = a[x] ^ a[x + 5] ^ a[x + 10] ^ a[x + 15] ^ a[x + 20];
            for (x = 0; x < 5; x++) begin
                d = col[(x + 4) % 5] ^ rot_left(col[(x + 1) % 5], 1);
                for (y = 0; y < 5; y++)
                    a[x + 5 * y] = a[x + 5 * y] ^ d;
            end
            x = 1;
            y = 0;
            cur = a[1];
            for (t = 0; t < 24; t++) begin
                ny = (2 * x + 3 * y) % 5;
                x = y;
                y = ny;
                nxt = a[x + 5 * y];
                a[x + 5 * y] = rot_left(cur, ((t + 1) * (t + 2) / 2) % 64);
                cur = nxt;
            end
            for (y = 0; y < 5; y++) begin
                for (x = 0; x < 5; x++)
                    row[x] = a[x + 5 * y];
                for (x = 0; x < 5; x++)
                    a[x + 5 * y] = row[x] ^ (~row[(x + 1) % 5] & row[(x + 2) % 5]);
            end
            for (j = 0; j < RC_BITS; j++) begin
                rc_bit = rc_lfsr[0];
                rc_lfsr = rc_lfsr[LFSR_W-1] ? ((rc_lfsr << 1) ^ LFSR_POLY) : (rc_lfsr << 1);
                if (rc_bit)
                    a[0][(1 << j) - 1] = ~a[0][(1 << j) - 1];
            end
        end
        return a;
    endfunction

    function automatic lane_t random_lane();
        lane_t       v;
        fill_style_t style;
        v = {$urandom, $urandom};
        style = ($urandom_range(0, 9) < 6) ? FILL_RANDOM
                                           : fill_style_t'($urandom_range(1, 3));
        case (style)
            FILL_SINGLE_BIT: begin
                v = ($urandom_range(0, 3) == 0) ? '0 : lane_t'(1) << $urandom_range(0, 63);
            end
            FILL_SOLID: begin
                v = $urandom_range(0, 1) ? '1 : '0;
            end
            FILL_SPARSE: begin
                v = v & {$urandom, $urandom} & {$urandom, $urandom};
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    task automatic send_lane(input lane_t v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random ready modes plus one long hold-off
    initial begin
        ready_mode_t mode;
        int          mode_left;
        int          phase;
        m_tready = 1'b0;
        mode = READY_ALWAYS;
        mode_left = 0;
        phase = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_out_req && !hold_out_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_out_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            phase++;
            case (mode)
                READY_ALWAYS:   m_tready <= 1'b1;
                READY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                READY_RARELY:   m_tready <= ($urandom_range(0, 3) == 0);
                default:        m_tready <= ((phase % 5) < 2);
            endcase
        end
    end

    always @(posedge aclk) begin
        out_lane_t got;
        out_lane_t want;
        int        k;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                loaded_state[loaded_count] = s_tdata;
                loaded_count++;
                if (loaded_count == LANES) begin
                    loaded_state = keccak_permute(loaded_state);
                    for (k = 0; k < LANES; k++)
                        lanes_due.push_back('{lane: loaded_state[k], number: 5'(k),
                                              is_last: (k == LANES - 1)});
                    loaded_count = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{lane: m_tdata, number: m_tuser, is_last: m_tlast};
                if (lanes_due.size() == 0) begin
                    if (error_count < REPORT_MAX)
                        $display("unexpected lane %0d: %h last %0b", m_tuser, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = lanes_due.pop_front();
                    if (got !== want) begin
                        if (error_count < REPORT_MAX)
                            $display("lane %0d: expected %h/%0d/%0b, got %h/%0d/%0b",
                                     want.number, want.lane, want.number, want.is_last,
                                     got.lane, got.number, got.is_last);
                        error_count++;
                    end
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("keccak_f1600_permutation: mismatch");
            $finish;
        end
    end

    initial begin
        int i;
        int s;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        for (i = 0; i < LANES; i++)
            send_lane(directed_lanes[i]);
        for (s = 0; s < RANDOM_SETS; s++) begin
            // for every sixth state, drain all pending lanes before it
            if (s % 6 == 0) begin
                s_tvalid <= 1'b0;
                wait (lanes_due.size() == 0);
                @(negedge aclk);
            end
            if (s == 1)
                hold_out_req = 1'b1;
            for (i = 0; i < LANES; i++)
                send_lane(random_lane());
        end
        s_tvalid <= 1'b0;
        wait (lanes_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("keccak_f1600_permutation: match");
        else
            $display("keccak_f1600_permutation: mismatch");
        $finish;
    end

endmodule

/* files.f */
src/kfp_pkg.sv
src/kfp_lfsr.sv
src/kfp_round.sv
src/keccak_f1600_permutation.sv
test/keccak_f1600_permutation_tb.sv
